// ===== rtl/h264d_pkg.sv =====
// Shared constants and types for the H.264 RTP depacketizer.
// Used by h264d_parse and h264_rtp_nal_depacketizer_top; no dependencies.
package h264d_pkg;

  localparam logic [7:0] NalTypeMask = 8'h1f;
  localparam logic [4:0] FuAType     = 5'd28;
  localparam logic [7:0] Top3Mask    = 8'he0;
  localparam logic [7:0] FuStartOnly = 8'h80;

  localparam int unsigned StartCodeLen = 4;
  localparam int unsigned IdxW         = 3;
  localparam logic [IdxW-1:0] StartCodeLastIdx = IdxW'(StartCodeLen - 1);
  localparam logic [IdxW-1:0] LongLastIdx      = IdxW'(StartCodeLen);

  typedef enum logic [1:0] {
    PosFirst  = 2'd0,
    PosSecond = 2'd1,
    PosLater  = 2'd2
  } pos_e;

  typedef struct packed {
    logic       has_start_code;
    logic [7:0] data;
    logic       byte_valid;
    logic       frame_end;
  } burst_t;

endpackage

// ===== rtl/h264d_parse.sv =====
// Packet parser: tracks byte position and FU-A indicator, and decodes one
// payload byte into a result burst descriptor. Depends on h264d_pkg.
module h264d_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        payload_byte_i,
  input  logic              first_in_packet_i,
  input  logic              last_in_packet_i,
  input  logic              marker_bit_i,
  output logic              has_result_o,
  output h264d_pkg::burst_t burst_o
);

  h264d_pkg::pos_e pos_q, pos_d, pos;
  logic [7:0]      ind_q, ind_d;
  logic            infrag_q, infrag_d;
  logic            has;
  logic            fend;

  always_comb begin
    pos      = first_in_packet_i ? h264d_pkg::PosFirst : pos_q;
    pos_d    = h264d_pkg::PosLater;
    ind_d    = ind_q;
    infrag_d = infrag_q;
    has      = 1'b1;
    burst_o.has_start_code = 1'b0;
    burst_o.data           = payload_byte_i;
    burst_o.byte_valid     = 1'b1;
    unique case (pos)
      h264d_pkg::PosFirst: begin
        pos_d = h264d_pkg::PosSecond;
        if ((payload_byte_i & h264d_pkg::NalTypeMask) != {3'b000, h264d_pkg::FuAType}) begin
          infrag_d               = 1'b0;
          burst_o.has_start_code = 1'b1;
        end else begin
          infrag_d = 1'b1;
          ind_d    = payload_byte_i;
          has      = 1'b0;
        end
      end
      h264d_pkg::PosSecond: begin
        if (infrag_q) begin
          if ((payload_byte_i & h264d_pkg::Top3Mask) == h264d_pkg::FuStartOnly) begin
            burst_o.has_start_code = 1'b1;
            burst_o.data = (payload_byte_i & h264d_pkg::NalTypeMask) |
                           (ind_q & h264d_pkg::Top3Mask);
          end else begin
            has = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    fend = last_in_packet_i && marker_bit_i;
    if (last_in_packet_i) begin
      pos_d = h264d_pkg::PosFirst;
    end
    if (fend && !has) begin
      burst_o.data       = 8'h00;
      burst_o.byte_valid = 1'b0;
    end
    burst_o.frame_end = fend;
    has_result_o      = has || fend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= h264d_pkg::PosFirst;
      ind_q    <= 8'h00;
      infrag_q <= 1'b0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      ind_q    <= ind_d;
      infrag_q <= infrag_d;
    end
  end

endmodule

// ===== rtl/h264_rtp_nal_depacketizer_top.sv =====
// Top level of the H.264 RTP depacketizer: parser plus result serializer.
// Depends on h264d_pkg and h264d_parse.
//
// Input channel (in_valid_i/in_ready_o) takes one RTP payload byte per item
// with first/last/marker flags. Output channel (out_valid_o/out_ready_i)
// gives an Annex-B byte stream, one result per item, with byte_valid,
// frame_end and run_last flags.
// Each input byte is decoded in the cycle it is accepted and its burst is
// held in one burst register. A burst is 0, 1 or 5 results (start code
// 00 00 00 01 plus a byte). The first result appears in the cycle after the
// input is accepted. Input bytes that give one result pass at one per cycle
// while the receiver is ready; a five-result burst holds the input until its
// last result is taken at the single output port. Bytes that give no result
// are taken without occupying the burst register.
// A new item is accepted in the cycle the last result of the current burst
// is taken, so bursts follow each other without a gap.
// Reset clears the parser state and empties the burst register.
// When the receiver stalls, the current result holds and the input stalls
// once the burst register is occupied.
module h264_rtp_nal_depacketizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  input  logic       first_in_packet_i,
  input  logic       last_in_packet_i,
  input  logic       marker_bit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       frame_end_o,
  output logic       run_last_o
);

  logic                          accept;
  logic                          has_result;
  logic                          pop_last;
  h264d_pkg::burst_t             burst_new;
  h264d_pkg::burst_t             burst_q, burst_d;
  logic                          busy_q, busy_d;
  logic [h264d_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [h264d_pkg::IdxW-1:0]    last_idx;

  h264d_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .payload_byte_i    (payload_byte_i),
    .first_in_packet_i (first_in_packet_i),
    .last_in_packet_i  (last_in_packet_i),
    .marker_bit_i      (marker_bit_i),
    .has_result_o      (has_result),
    .burst_o           (burst_new)
  );

  assign last_idx   = burst_q.has_start_code ? h264d_pkg::LongLastIdx : '0;
  assign pop_last   = busy_q && out_ready_i && (idx_q == last_idx);
  assign in_ready_o = !busy_q || pop_last;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    burst_d = burst_q;
    if (busy_q && out_ready_i) begin
      idx_d = idx_q + 1'b1;
    end
    if (pop_last) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d  = has_result;
      idx_d   = '0;
      burst_d = burst_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
  end

  always_comb begin
    out_valid_o = busy_q;
    if (burst_q.has_start_code && (idx_q < h264d_pkg::LongLastIdx)) begin
      out_byte_o   = (idx_q == h264d_pkg::StartCodeLastIdx) ? 8'h01 : 8'h00;
      byte_valid_o = 1'b1;
      frame_end_o  = 1'b0;
      run_last_o   = 1'b0;
    end else begin
      out_byte_o   = burst_q.data;
      byte_valid_o = burst_q.byte_valid;
      frame_end_o  = burst_q.frame_end;
      run_last_o   = 1'b1;
    end
  end

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= last_idx))
    else $error("burst index out of range");

  a_accept_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!out_valid_o || (out_ready_i && run_last_o)))
    else $error("item accepted while burst still pending");

  a_bare_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (frame_end_o && run_last_o))
    else $error("invalid byte without frame end");

  a_mid_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> (byte_valid_o && !frame_end_o))
    else $error("start code result carries end flags");

endmodule

// ===== tb/h264_rtp_nal_depacketizer_top_test.sv =====
// Self-checking testbench for h264_rtp_nal_depacketizer_top: RTP payload bytes in,
// Annex-B stream bytes out, checked against an in-bench depacketizer predictor.
// Depends on h264d_pkg and the RTL of h264_rtp_nal_depacketizer_top.
module h264_rtp_nal_depacketizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       frame_end;
    logic       run_last;
  } annexb_byte_t;

  class annexb_scoreboard;
    annexb_byte_t    pending_q[$];
    annexb_byte_t    burst_q[$];
    h264d_pkg::pos_e byte_pos;
    logic [7:0]      fu_indicator;
    logic            in_fu;
    int              errors;

    function new();
      byte_pos     = h264d_pkg::PosFirst;
      fu_indicator = '0;
      in_fu        = 1'b0;
      errors       = 0;
    endfunction

    function void add_byte(logic [7:0] b);
      burst_q.push_back('{data: b, byte_valid: 1'b1, frame_end: 1'b0, run_last: 1'b0});
    endfunction

    function void add_start_code();
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h01);
    endfunction

    function void note_payload(logic [7:0] b, logic first, logic last, logic marker);
      h264d_pkg::pos_e pos;
      burst_q.delete();
      pos = first ? h264d_pkg::PosFirst : byte_pos;
      case (pos)
        h264d_pkg::PosFirst: begin
          if (b[4:0] != h264d_pkg::FuAType) begin
            in_fu = 1'b0;
            add_start_code();
            add_byte(b);
          end else begin
            in_fu        = 1'b1;
            fu_indicator = b;
          end
          byte_pos = h264d_pkg::PosSecond;
        end
        h264d_pkg::PosSecond: begin
          if (in_fu) begin
            if ((b & h264d_pkg::Top3Mask) == h264d_pkg::FuStartOnly) begin
              add_start_code();
              add_byte((b & h264d_pkg::NalTypeMask) | (fu_indicator & h264d_pkg::Top3Mask));
            end
          end else begin
            add_byte(b);
          end
          byte_pos = h264d_pkg::PosLater;
        end
        default: begin
          add_byte(b);
          byte_pos = h264d_pkg::PosLater;
        end
      endcase
      if (last) begin
        byte_pos = h264d_pkg::PosFirst;
        if (marker) begin
          if (burst_q.size() == 0)
            burst_q.push_back('{data: 8'h00, byte_valid: 1'b0, frame_end: 1'b0, run_last: 1'b0});
          burst_q[burst_q.size()-1].frame_end = 1'b1;
        end
      end
      if (burst_q.size() > 0)
        burst_q[burst_q.size()-1].run_last = 1'b1;
      foreach (burst_q[i]) pending_q.push_back(burst_q[i]);
    endfunction

    function void check_stream_byte(logic [7:0] data, logic bv, logic fe, logic rl);
      annexb_byte_t exp_b;
      if (pending_q.size() == 0) begin
        $error("unexpected result: out_byte %h byte_valid %b frame_end %b run_last %b",
               data, bv, fe, rl);
        errors++;
        return;
      end
      exp_b = pending_q.pop_front();
      if (exp_b.data !== data) begin
        $error("out_byte: expected %h, actual %h", exp_b.data, data);
        errors++;
      end
      if (exp_b.byte_valid !== bv) begin
        $error("byte_valid: expected %b, actual %b", exp_b.byte_valid, bv);
        errors++;
      end
      if (exp_b.frame_end !== fe) begin
        $error("frame_end: expected %b, actual %b", exp_b.frame_end, fe);
        errors++;
      end
      if (exp_b.run_last !== rl) begin
        $error("run_last: expected %b, actual %b", exp_b.run_last, rl);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 20;

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       in_valid_i        = 1'b0;
  logic       in_ready_o;
  logic [7:0] payload_byte_i    = '0;
  logic       first_in_packet_i = 1'b0;
  logic       last_in_packet_i  = 1'b0;
  logic       marker_bit_i      = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i       = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       frame_end_o;
  logic       run_last_o;

  annexb_scoreboard stream_sb;
  int unsigned      send_idle_pct = 9;
  int unsigned      recv_idle_pct = 68;
  int unsigned      items_sent    = 0;
  int unsigned      stall_cycles  = 0;

  h264_rtp_nal_depacketizer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .payload_byte_i   (payload_byte_i),
    .first_in_packet_i(first_in_packet_i),
    .last_in_packet_i (last_in_packet_i),
    .marker_bit_i     (marker_bit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .frame_end_o      (frame_end_o),
    .run_last_o       (run_last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        stream_sb.check_stream_byte(out_byte_o, byte_valid_o, frame_end_o, run_last_o);
      if (in_valid_i && in_ready_o)
        stream_sb.note_payload(payload_byte_i, first_in_packet_i, last_in_packet_i,
                               marker_bit_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first, input logic last,
                           input logic marker);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    payload_byte_i    <= b;
    first_in_packet_i <= first;
    last_in_packet_i  <= last;
    marker_bit_i      <= marker;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (stream_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_packet();
    int unsigned len;
    logic [7:0]  b;
    logic        marker;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 4))
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      return;
    end
    len    = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
    marker = ($urandom_range(2) == 0);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (i == 0 && $urandom_range(1))
        b[4:0] = h264d_pkg::FuAType;
      else if (i == 1 && $urandom_range(3) != 0)
        b[7:5] = h264d_pkg::FuStartOnly[7:5];
      send_item(b, (i == 0) ? ($urandom_range(7) != 0) : 1'b0, i == len - 1,
                (i == len - 1) ? marker : 1'($urandom_range(1)));
    end
  endtask

  task automatic run_random_phase(input int unsigned target);
    while (items_sent < target) send_random_packet();
  endtask

  initial begin
    stream_sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0, 1'b1);
    send_item(8'h80, 1'b0, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1, 1'b1);
    send_item(8'h7c, 1'b1, 1'b0, 1'b0);
    send_item(8'h85, 1'b0, 1'b0, 1'b0);
    send_item(8'haa, 1'b0, 1'b1, 1'b0);
    send_item(8'h5c, 1'b1, 1'b0, 1'b0);
    send_item(8'ha1, 1'b0, 1'b1, 1'b1);
    send_item(8'hfc, 1'b1, 1'b0, 1'b0);
    send_item(8'hdf, 1'b0, 1'b0, 1'b0);
    send_item(8'h55, 1'b0, 1'b1, 1'b1);
    send_item(8'h1c, 1'b1, 1'b1, 1'b0);
    send_item(8'hfc, 1'b1, 1'b1, 1'b1);
    send_item(8'h41, 1'b0, 1'b0, 1'b0);
    send_item(8'h01, 1'b0, 1'b1, 1'b0);
    send_item(8'h09, 1'b1, 1'b0, 1'b0);
    send_item(8'h3c, 1'b1, 1'b0, 1'b0);
    send_item(8'h9f, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1, 1'b1);

    run_random_phase(165);
    wait_drained();

    send_idle_pct = 68;
    recv_idle_pct = 9;
    run_random_phase(310);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(455);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (stream_sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
